// ===== hdl/arp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the AArch64 relocation patcher.
// No dependencies; used by arp_encode and arm64_reloc_patcher_core.
package arp_pkg;

    localparam logic [63:0] PAGE_MASK  = 64'hffff_ffff_ffff_f000;
    localparam logic [31:0] LDST_MASK  = 32'h3b00_0000;
    localparam logic [31:0] LDST_MATCH = 32'h3900_0000;
    localparam logic [31:0] Q128_BITS  = 32'h0480_0000;
    localparam int          REACH_BIT  = 27;

    typedef enum logic [3:0] {
        KIND_UNSIGNED       = 4'd0,
        KIND_SUBTRACTOR     = 4'd1,
        KIND_BRANCH26       = 4'd2,
        KIND_PAGE21         = 4'd3,
        KIND_PAGEOFF12      = 4'd4,
        KIND_GOT_PAGE21     = 4'd5,
        KIND_GOT_PAGEOFF12  = 4'd6,
        KIND_POINTER_TO_GOT = 4'd7,
        KIND_TLV_PAGE21     = 4'd8,
        KIND_TLV_PAGEOFF12  = 4'd9
    } reloc_kind_t;

    typedef enum logic [1:0] {
        WK_NONE = 2'd0,
        WK_32   = 2'd1,
        WK_64   = 2'd2
    } write_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNDEFINED   = 2'd1,
        ST_UNKNOWN     = 2'd2,
        ST_UNREACHABLE = 2'd3
    } status_t;

    typedef enum logic {
        CFG_ERROR_ON_UNDEFINED = 1'b0,
        CFG_TLS_BASE           = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [3:0]         reloc_kind;
        logic signed [63:0] addend;
        logic [63:0]        target_addr;
        logic [63:0]        minus_addr;
        logic [63:0]        place_addr;
        logic               pc_relative;
        logic               wide_write;
        logic               in_tls_section;
        logic [63:0]        thunk_addr;
        logic               undefined_symbol;
        logic [63:0]        old_word;
    } item_t;

    typedef struct packed {
        logic [63:0] new_word;
        logic [1:0]  write_kind;
        logic [1:0]  status;
    } result_t;

    // Value stage: summed value plus what the encoder still needs
    typedef struct packed {
        logic [3:0]  reloc_kind;
        logic [63:0] value;
        logic [63:0] place_addr;
        logic [63:0] thunk_addr;
        logic [63:0] old_word;
        logic        pc_relative;
        logic        wide_write;
        logic [1:0]  early_status;
    } value_stage_t;

endpackage

// ===== hdl/arp_encode.sv =====
`timescale 1ns / 1ps
// Encoder: turns the formed value into the patched word, write kind and status.
// Depends on arp_pkg.
module arp_encode
(
    input  arp_pkg::value_stage_t stage,
    output arp_pkg::result_t      result
);

    logic [31:0] insn;
    logic [63:0] raw_value;
    logic [63:0] branch_disp;
    logic [63:0] thunk_disp;
    logic        branch_reach;
    logic        thunk_reach;
    logic [63:0] chosen_disp;
    logic [63:0] page_diff;
    logic [31:0] page_bits;
    logic [2:0]  scale;
    logic [11:0] off_bits;

    always_comb
    begin
        insn        = stage.old_word[31:0];
        raw_value   = stage.pc_relative ? stage.value - stage.place_addr : stage.value;
        branch_disp = stage.value - stage.place_addr;
        thunk_disp  = stage.thunk_addr - stage.place_addr;
        branch_reach = (&branch_disp[63:arp_pkg::REACH_BIT])
                     | ~(|branch_disp[63:arp_pkg::REACH_BIT]);
        thunk_reach  = (&thunk_disp[63:arp_pkg::REACH_BIT])
                     | ~(|thunk_disp[63:arp_pkg::REACH_BIT]);
        chosen_disp = branch_reach ? branch_disp : thunk_disp;

        page_diff = (stage.value & arp_pkg::PAGE_MASK)
                  - (stage.place_addr & arp_pkg::PAGE_MASK);
        page_bits = {1'b0, page_diff[13:12], 24'd0, 5'd0}
                  | {8'd0, page_diff[32:14], 5'd0};

        scale = 3'd0;
        if ((insn & arp_pkg::LDST_MASK) == arp_pkg::LDST_MATCH)
        begin
            scale = {1'b0, insn[31:30]};
            if (scale == 3'd0 && (insn & arp_pkg::Q128_BITS) == arp_pkg::Q128_BITS)
            begin
                scale = 3'd4;
            end
        end
        off_bits = stage.value[11:0] >> scale;

        result.new_word   = stage.old_word;
        result.write_kind = arp_pkg::WK_NONE;
        result.status     = stage.early_status;

        if (stage.early_status == arp_pkg::ST_OK)
        begin
            case (stage.reloc_kind)
                arp_pkg::KIND_UNSIGNED,
                arp_pkg::KIND_SUBTRACTOR,
                arp_pkg::KIND_POINTER_TO_GOT:
                begin
                    if (stage.wide_write)
                    begin
                        result.new_word   = raw_value;
                        result.write_kind = arp_pkg::WK_64;
                    end
                    else
                    begin
                        result.new_word   = {32'd0, raw_value[31:0]};
                        result.write_kind = arp_pkg::WK_32;
                    end
                end
                arp_pkg::KIND_BRANCH26:
                begin
                    if (branch_reach || thunk_reach)
                    begin
                        result.new_word   = {32'd0, insn | {6'd0, chosen_disp[27:2]}};
                        result.write_kind = arp_pkg::WK_32;
                    end
                    else
                    begin
                        result.status = arp_pkg::ST_UNREACHABLE;
                    end
                end
                arp_pkg::KIND_PAGE21,
                arp_pkg::KIND_GOT_PAGE21,
                arp_pkg::KIND_TLV_PAGE21:
                begin
                    result.new_word   = {32'd0, insn | page_bits};
                    result.write_kind = arp_pkg::WK_32;
                end
                default:
                begin
                    result.new_word   = {32'd0, insn | {10'd0, off_bits, 10'd0}};
                    result.write_kind = arp_pkg::WK_32;
                end
            endcase
        end
    end

endmodule

// ===== hdl/arm64_reloc_patcher_core.sv =====
`timescale 1ns / 1ps
// Top level of the AArch64 Mach-O relocation patcher.
// Depends on arp_pkg and arp_encode.
//
// One relocation word enters per cycle while the output side is not stalled, and
// its result word leaves from the result register; the three register stages
// (input, summed value, result) keep the sustained rate at one word per cycle
// while result_ready stays high. Configuration writes are always taken (cfg_ready
// is tied high) and must be issued only while the block holds no word.
module arm64_reloc_patcher_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  arp_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_ready,
    output arp_pkg::result_t    result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data
);

    logic                  error_on_undefined_reg;
    logic [63:0]           tls_base_reg;

    logic                  in_valid_reg;
    arp_pkg::item_t        in_reg;
    logic                  mid_valid_reg;
    arp_pkg::value_stage_t mid_reg;
    arp_pkg::value_stage_t mid_next;
    logic                  out_valid_reg;
    arp_pkg::result_t      out_reg;
    arp_pkg::result_t      out_next;

    logic                  out_load;
    logic                  mid_load;
    logic                  in_load;
    logic [63:0]           minus_term;
    logic [63:0]           tls_term;

    assign cfg_ready  = 1'b1;
    assign out_load   = !out_valid_reg || result_ready;
    assign mid_load   = !mid_valid_reg || out_load;
    assign in_load    = !in_valid_reg || mid_load;
    assign item_ready = in_load;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_on_undefined_reg <= 1'b1;
            tls_base_reg           <= 64'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                arp_pkg::CFG_ERROR_ON_UNDEFINED: error_on_undefined_reg <= cfg_data[0];
                arp_pkg::CFG_TLS_BASE:           tls_base_reg           <= cfg_data;
                default:                         tls_base_reg           <= tls_base_reg;
            endcase
        end
    end

    // Value stage: form addend + target - minus (subtractor only) - tls_base (TLS only), flag early errors
    always_comb
    begin
        minus_term = (in_reg.reloc_kind == arp_pkg::KIND_SUBTRACTOR) ? in_reg.minus_addr
                                                                      : 64'd0;
        tls_term   = in_reg.in_tls_section ? tls_base_reg : 64'd0;

        mid_next.reloc_kind  = in_reg.reloc_kind;
        mid_next.value       = in_reg.addend + in_reg.target_addr - minus_term - tls_term;
        mid_next.place_addr  = in_reg.place_addr;
        mid_next.thunk_addr  = in_reg.thunk_addr;
        mid_next.old_word    = in_reg.old_word;
        mid_next.pc_relative = in_reg.pc_relative;
        mid_next.wide_write  = in_reg.wide_write;

        if (in_reg.undefined_symbol && error_on_undefined_reg)
        begin
            mid_next.early_status = arp_pkg::ST_UNDEFINED;
        end
        else if (in_reg.reloc_kind > arp_pkg::KIND_TLV_PAGEOFF12)
        begin
            mid_next.early_status = arp_pkg::ST_UNKNOWN;
        end
        else
        begin
            mid_next.early_status = arp_pkg::ST_OK;
        end
    end

    arp_encode u_encode
    (
        .stage  (mid_reg),
        .result (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= item_valid;
            end
            if (mid_load)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && item_valid)
        begin
            in_reg <= item;
        end
        if (mid_load && in_valid_reg)
        begin
            mid_reg <= mid_next;
        end
        if (out_load && mid_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

endmodule
